[rtl/stereo_vu_meter_peak_hold_core_macros.svh]
// Assertion macros for the stereo VU meter core.
// Used by stereo_vu_meter_peak_hold_core.sv; expects clock and reset in scope.
`ifndef STEREO_VU_METER_PEAK_HOLD_CORE_MACROS_SVH
`define STEREO_VU_METER_PEAK_HOLD_CORE_MACROS_SVH

// same-cycle implication
`define SVMPH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SVMPH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/svmph_pkg.sv]
// Shared types, constants and the log10 curve generator for the VU meter core.
// No dependencies; imported by svmph_chan and stereo_vu_meter_peak_hold_core.
`timescale 1ns / 1ps

package svmph_pkg;

   localparam int SAMPLE_W    = 18;
   localparam int MAG_W       = 18;
   localparam int SUM_W       = 36;
   localparam int COUNT_W     = 17;
   localparam int LEVEL_W     = 17;
   localparam int HOLD_W      = 16;
   localparam int INTERVAL_W  = 16;
   localparam int FACTOR_W    = 17;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 4;
   localparam int DIGIT_W     = 4;
   localparam int ACC_DIGITS  = SUM_W / DIGIT_W;
   localparam int DIV_STEPS   = SUM_W;
   localparam int MUL_STEPS   = FACTOR_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int PROD_W      = LEVEL_W + 1 + FACTOR_W;
   localparam int DELTA_W     = LEVEL_W + 2;

   localparam int UPDATE_RATE_HZ      = 30;
   localparam int DEFAULT_SAMPLE_RATE = 44100;

   localparam logic [LEVEL_W-1:0]    FULL_SCALE = LEVEL_W'(65536);
   localparam logic [COUNT_W-1:0]    COUNT_MAX  = '1;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET =
      INTERVAL_W'((DEFAULT_SAMPLE_RATE / UPDATE_RATE_HZ) % 65536);
   localparam logic [HOLD_W-1:0]     HOLD_RESET   = HOLD_W'(5);
   localparam logic [FACTOR_W-1:0]   ATTACK_RESET = FACTOR_W'(65536);
   localparam logic [FACTOR_W-1:0]   DECAY_RESET  = FACTOR_W'(6554);

   localparam logic [CSR_INDEX_W-1:0] CSR_UPDATE_INTERVAL   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_HOLD_BUFFERS = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_FACTOR     = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_FACTOR      = CSR_INDEX_W'(3);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_IDX,
      ST_ROM,
      ST_MSEL,
      ST_MUL,
      ST_FIN,
      ST_PEAK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic acc;
      logic acc_last;
      logic div;
      logic idx;
      logic rom;
      logic msel;
      logic mul;
      logic fin;
      logic peak;
   } ctl_type;

   // round(65536*log10(p/q)) in integers, q = 1000*n, p = q + 65534*i
   function automatic logic [LEVEL_W-1:0] log_entry(input int unsigned n,
                                                    input int unsigned i);
      logic [63:0] q;
      logic [63:0] p;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] y;
      logic [63:0] frac;
      logic [63:0] l2;
      logic [63:0] prod;
      int unsigned k;
      q    = 64'(n) * 64'd1000;
      p    = q + 64'd65534 * 64'(i);
      k    = 0;
      rem  = '0;
      y    = '0;
      frac = '0;
      for (int j = 0; j < 16; j++) begin
         if ((q << (k + 1)) <= p) begin
            k = k + 1;
         end
      end
      num = p << 30;
      den = q << k;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            y[b] = 1'b1;
         end
      end
      for (int r = 0; r < 16; r++) begin
         y    = (y * y) >> 30;
         frac = frac << 1;
         if (y >= 64'h8000_0000) begin
            frac[0] = 1'b1;
            y       = y >> 1;
         end
      end
      l2   = (64'(k) << 16) | frac;
      prod = l2 * 64'd646456993 + 64'h4000_0000;
      return prod[31+LEVEL_W-1:31];
   endfunction

endpackage

[rtl/svmph_chan.sv]
// One channel of the VU meter: digit-serial accumulator, bit-serial divider,
// log10 ROM, shift-add smoothing multiplier and peak hold. Uses svmph_pkg.
`timescale 1ns / 1ps

module svmph_chan
   import svmph_pkg::*;
#(
   parameter int LOG_TABLE_ENTRIES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctl_type                    ctl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic [COUNT_W-1:0]         frame_count,
   input  logic [HOLD_W-1:0]          hold_buffers,
   input  logic [FACTOR_W-1:0]        attack_factor,
   input  logic [FACTOR_W-1:0]        decay_factor,
   output logic [LEVEL_W-1:0]         level,
   output logic                       peak
);

   localparam int IDX_W  = $clog2(LOG_TABLE_ENTRIES);
   localparam int IPROD_W = LEVEL_W + $clog2(LOG_TABLE_ENTRIES + 1);

   typedef logic [LEVEL_W-1:0] rom_type [LOG_TABLE_ENTRIES];

   function automatic rom_type build_rom();
      rom_type t;
      for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
         t[i] = log_entry(LOG_TABLE_ENTRIES, i);
      end
      return t;
   endfunction

   localparam rom_type LOG_ROM = build_rom();

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic                carry_ff, carry_in;
   logic                clip_ff, clip_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [LEVEL_W-1:0]  quo_ff, quo_in;
   logic                big_ff, big_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [LEVEL_W-1:0]  target_ff;
   logic                dec_ff, dec_in;
   logic [LEVEL_W-1:0]  diff_ff, diff_in;
   logic [LEVEL_W:0]    hi_ff, hi_in;
   logic [FACTOR_W-1:0] lo_ff, lo_in;
   logic [LEVEL_W-1:0]  smooth_ff, smooth_in;
   logic [HOLD_W-1:0]   hold_ff, hold_in;
   logic                peak_ff, peak_in;

   logic [MAG_W-1:0]     mag_now;
   logic                 clip_now;
   logic [DIGIT_W:0]     digit_sum;
   logic [COUNT_W:0]     div_trial;
   logic [COUNT_W:0]     div_diff;
   logic                 div_ge;
   logic [IPROD_W-1:0]   idx_prod;
   logic                 go_down;
   logic [FACTOR_W-1:0]  factor_raw;
   logic [FACTOR_W-1:0]  factor;
   logic [LEVEL_W+1:0]   mul_add;
   logic [PROD_W-1:0]    product;
   logic [DELTA_W-1:0]   delta;
   logic [DELTA_W:0]     fin_val;

   always_comb begin
      mag_now    = sample[SAMPLE_W-1] ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);
      clip_now   = mag_now > MAG_W'(FULL_SCALE);
      digit_sum  = {1'b0, sum_ff[DIGIT_W-1:0]} + {1'b0, mag_ff[DIGIT_W-1:0]}
                   + (DIGIT_W+1)'(carry_ff);
      div_trial  = {rem_ff, sum_ff[SUM_W-1]};
      div_ge     = div_trial >= {1'b0, frame_count};
      div_diff   = div_trial - {1'b0, frame_count};
      idx_prod   = IPROD_W'(quo_ff) * IPROD_W'(LOG_TABLE_ENTRIES);
      go_down    = smooth_ff > target_ff;
      factor_raw = go_down ? decay_factor : attack_factor;
      factor     = (factor_raw > FACTOR_W'(FULL_SCALE)) ? FACTOR_W'(FULL_SCALE) : factor_raw;
      mul_add    = {1'b0, hi_ff} + (lo_ff[0] ? (LEVEL_W+2)'(diff_ff) : '0);
      product    = {hi_ff, lo_ff};
      // round half up on the Q19.16 product
      delta      = DELTA_W'(product[PROD_W-1:16]) + DELTA_W'(product[15]);
      fin_val    = dec_ff ? ((DELTA_W+1)'(smooth_ff) - (DELTA_W+1)'(delta))
                          : ((DELTA_W+1)'(smooth_ff) + (DELTA_W+1)'(delta));
   end

   always_comb begin
      sum_in    = sum_ff;
      mag_in    = mag_ff;
      carry_in  = carry_ff;
      clip_in   = clip_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      big_in    = big_ff;
      idx_in    = idx_ff;
      dec_in    = dec_ff;
      diff_in   = diff_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      smooth_in = smooth_ff;
      hold_in   = hold_ff;
      peak_in   = peak_ff;
      if (ctl.load) begin
         mag_in   = mag_now;
         carry_in = 1'b0;
         clip_in  = clip_ff | clip_now;
         rem_in   = '0;
         quo_in   = '0;
         big_in   = 1'b0;
      end
      if (ctl.acc) begin
         // rotate the sum one digit; aligned again after the last digit
         sum_in   = {digit_sum[DIGIT_W-1:0], sum_ff[SUM_W-1:DIGIT_W]};
         mag_in   = mag_ff >> DIGIT_W;
         carry_in = digit_sum[DIGIT_W];
         if (ctl.acc_last && digit_sum[DIGIT_W]) begin
            sum_in = '1;
         end
      end
      if (ctl.div) begin
         sum_in = sum_ff << 1;
         rem_in = div_ge ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
         quo_in = {quo_ff[LEVEL_W-2:0], div_ge};
         big_in = big_ff | quo_ff[LEVEL_W-1];
      end
      if (ctl.idx) begin
         idx_in = big_ff ? IDX_W'(LOG_TABLE_ENTRIES - 1) : IDX_W'(idx_prod >> LEVEL_W);
      end
      if (ctl.msel) begin
         dec_in  = go_down;
         diff_in = go_down ? (smooth_ff - target_ff) : (target_ff - smooth_ff);
         hi_in   = '0;
         lo_in   = factor;
      end
      if (ctl.mul) begin
         hi_in = mul_add[LEVEL_W+1:1];
         lo_in = {mul_add[0], lo_ff[FACTOR_W-1:1]};
      end
      if (ctl.fin) begin
         smooth_in = (fin_val > (DELTA_W+1)'(FULL_SCALE)) ? FULL_SCALE
                                                          : fin_val[LEVEL_W-1:0];
         sum_in    = '0;
      end
      if (ctl.peak) begin
         clip_in = 1'b0;
         if (clip_ff) begin
            peak_in = 1'b1;
            hold_in = hold_buffers;
         end else if (hold_ff == '0) begin
            peak_in = 1'b0;
         end else begin
            hold_in = hold_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         carry_ff  <= 1'b0;
         clip_ff   <= 1'b0;
         smooth_ff <= '0;
         hold_ff   <= '0;
         peak_ff   <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         carry_ff  <= carry_in;
         clip_ff   <= clip_in;
         smooth_ff <= smooth_in;
         hold_ff   <= hold_in;
         peak_ff   <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      big_ff  <= big_in;
      idx_ff  <= idx_in;
      dec_ff  <= dec_in;
      diff_ff <= diff_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.rom) begin
         target_ff <= LOG_ROM[idx_ff];
      end
   end

   assign level = smooth_ff;
   assign peak  = peak_ff;

endmodule

[rtl/stereo_vu_meter_peak_hold_core.sv]
// Ordinary frame: after accept, 9 nibble-serial add steps, then idle again for the next accept.
// Buffer end without level update: add steps, peak step, then the output state registers the result.
// Buffer end with update: add steps, the 36-step bit-serial divider, index, ROM, select, the 17-step
// shift-add smoothing multiplier, finish, peak and output states in turn; one frame in flight at a time.
// Synchronous active-high reset clears sums, levels, peak state and loads default CSRs.
// Uses svmph_pkg, svmph_chan and the core assertion macros header.
`timescale 1ns / 1ps
`include "stereo_vu_meter_peak_hold_core_macros.svh"

module stereo_vu_meter_peak_hold_core
   import svmph_pkg::*;
#(
   parameter int LOG_TABLE_ENTRIES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_left,
   input  logic signed [SAMPLE_W-1:0] req_sample_right,
   input  logic                       req_end_of_buffer,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [LEVEL_W-1:0]         rsp_level_left,
   output logic [LEVEL_W-1:0]         rsp_level_right,
   output logic [LEVEL_W-1:0]         rsp_level_mean,
   output logic                       rsp_peak_left,
   output logic                       rsp_peak_right,
   output logic                       rsp_peak_any,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   state_type state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  eob_ff, eob_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [HOLD_W-1:0]     hold_cfg_ff, hold_cfg_in;
   logic [FACTOR_W-1:0]   attack_ff, attack_in;
   logic [FACTOR_W-1:0]   decay_ff, decay_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]    rsp_level_left_ff, rsp_level_left_in;
   logic [LEVEL_W-1:0]    rsp_level_right_ff, rsp_level_right_in;
   logic [LEVEL_W-1:0]    rsp_level_mean_ff, rsp_level_mean_in;
   logic                  rsp_peak_left_ff, rsp_peak_left_in;
   logic                  rsp_peak_right_ff, rsp_peak_right_in;

   ctl_type             ctl;
   logic                accept;
   logic                out_load;
   logic                step_last;
   logic                do_update;
   logic [LEVEL_W-1:0]  level_left;
   logic [LEVEL_W-1:0]  level_right;
   logic                peak_left;
   logic                peak_right;
   logic [LEVEL_W:0]    level_pair;

   svmph_chan #(
      .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
   ) u_chan_left (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sample        (req_sample_left),
      .frame_count   (count_ff),
      .hold_buffers  (hold_cfg_ff),
      .attack_factor (attack_ff),
      .decay_factor  (decay_ff),
      .level         (level_left),
      .peak          (peak_left)
   );

   svmph_chan #(
      .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
   ) u_chan_right (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sample        (req_sample_right),
      .frame_count   (count_ff),
      .hold_buffers  (hold_cfg_ff),
      .attack_factor (attack_ff),
      .decay_factor  (decay_ff),
      .level         (level_right),
      .peak          (peak_right)
   );

   always_comb begin
      accept    = req_valid && req_ready;
      do_update = count_ff > COUNT_W'(interval_ff);
      case (state_ff)
         ST_ACC:  step_last = step_ff == STEP_W'(ACC_DIGITS - 1);
         ST_DIV:  step_last = step_ff == STEP_W'(DIV_STEPS - 1);
         ST_MUL:  step_last = step_ff == STEP_W'(MUL_STEPS - 1);
         default: step_last = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (step_last) begin
               if (!eob_ff) begin
                  state_in = ST_IDLE;
               end else if (do_update) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_PEAK;
               end
            end
         end
         ST_DIV: begin
            if (step_last) begin
               state_in = ST_IDX;
            end
         end
         ST_IDX:  state_in = ST_ROM;
         ST_ROM:  state_in = ST_MSEL;
         ST_MSEL: state_in = ST_MUL;
         ST_MUL: begin
            if (step_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:  state_in = ST_PEAK;
         ST_PEAK: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready    = 1'b0;
      out_load     = 1'b0;
      ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         ST_ACC: begin
            ctl.acc      = 1'b1;
            ctl.acc_last = step_last;
         end
         ST_DIV:  ctl.div  = 1'b1;
         ST_IDX:  ctl.idx  = 1'b1;
         ST_ROM:  ctl.rom  = 1'b1;
         ST_MSEL: ctl.msel = 1'b1;
         ST_MUL:  ctl.mul  = 1'b1;
         ST_FIN:  ctl.fin  = 1'b1;
         ST_PEAK: ctl.peak = 1'b1;
         ST_OUT:  out_load = !rsp_valid_ff || rsp_ready;
         default: ctl = '0;
      endcase
   end

   always_comb begin
      step_in = '0;
      if ((state_ff == ST_ACC || state_ff == ST_DIV || state_ff == ST_MUL) && !step_last) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      eob_in   = eob_ff;
      if (accept) begin
         eob_in = req_end_of_buffer;
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (ctl.fin) begin
         count_in = '0;
      end
   end

   always_comb begin
      interval_in = interval_ff;
      hold_cfg_in = hold_cfg_ff;
      attack_in   = attack_ff;
      decay_in    = decay_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_UPDATE_INTERVAL:   interval_in = csr_wdata[INTERVAL_W-1:0];
            CSR_PEAK_HOLD_BUFFERS: hold_cfg_in = csr_wdata[HOLD_W-1:0];
            CSR_ATTACK_FACTOR:     attack_in   = csr_wdata[FACTOR_W-1:0];
            CSR_DECAY_FACTOR:      decay_in    = csr_wdata[FACTOR_W-1:0];
            default:               interval_in = interval_ff;
         endcase
      end
   end

   always_comb begin
      level_pair         = {1'b0, level_left} + {1'b0, level_right};
      rsp_level_left_in  = rsp_level_left_ff;
      rsp_level_right_in = rsp_level_right_ff;
      rsp_level_mean_in  = rsp_level_mean_ff;
      rsp_peak_left_in   = rsp_peak_left_ff;
      rsp_peak_right_in  = rsp_peak_right_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      if (out_load) begin
         rsp_valid_in       = 1'b1;
         rsp_level_left_in  = level_left;
         rsp_level_right_in = level_right;
         rsp_level_mean_in  = level_pair[LEVEL_W:1];
         rsp_peak_left_in   = peak_left;
         rsp_peak_right_in  = peak_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         eob_ff       <= 1'b0;
         interval_ff  <= INTERVAL_RESET;
         hold_cfg_ff  <= HOLD_RESET;
         attack_ff    <= ATTACK_RESET;
         decay_ff     <= DECAY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         eob_ff       <= eob_in;
         interval_ff  <= interval_in;
         hold_cfg_ff  <= hold_cfg_in;
         attack_ff    <= attack_in;
         decay_ff     <= decay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_left_ff  <= rsp_level_left_in;
      rsp_level_right_ff <= rsp_level_right_in;
      rsp_level_mean_ff  <= rsp_level_mean_in;
      rsp_peak_left_ff   <= rsp_peak_left_in;
      rsp_peak_right_ff  <= rsp_peak_right_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level_left  = rsp_level_left_ff;
   assign rsp_level_right = rsp_level_right_ff;
   assign rsp_level_mean  = rsp_level_mean_ff;
   assign rsp_peak_left   = rsp_peak_left_ff;
   assign rsp_peak_right  = rsp_peak_right_ff;
   assign rsp_peak_any    = rsp_peak_left_ff | rsp_peak_right_ff;

   `SVMPH_ASSERT_NEXT(a_accept_starts_acc, req_valid && req_ready, state_ff == ST_ACC,
      "accepted beat did not start accumulation")
   `SVMPH_ASSERT_SAME(a_rsp_from_out, rsp_valid_ff && !$past(rsp_valid_ff),
      $past(state_ff) == ST_OUT, "result beat raised outside output state")
   `SVMPH_ASSERT_NEXT(a_fin_clears_count, state_ff == ST_FIN, count_ff == '0,
      "level update left frame count")
   `SVMPH_ASSERT_SAME(a_level_range, rsp_valid_ff,
      rsp_level_left_ff <= FULL_SCALE && rsp_level_right_ff <= FULL_SCALE,
      "level above full scale")

endmodule
